FILE: hw/rtl/assert_macros.svh
// Assertion macros for the top level, circular_queue_with_listing, which checks its own logic.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define CQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define CQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/cqwl_pkg.sv
// Types and constants of the circular queue with listing.
// Used by cqwl_ctrl, cqwl_dp and circular_queue_with_listing.
package cqwl_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Input item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } st_t;

    // Source of the next result item
    typedef enum logic [1:0] {
        OUT_WORD  = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_EMPTY = 2'd2,
        OUT_MEM   = 2'd3
    } out_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     wr_en;       // store input word at tail
        logic     pop;         // read at head, advance head
        logic     list_start;  // read at head, start walk
        logic     list_next;   // read at walk index, advance walk
        logic     out_load;    // load output register
        out_sel_t out_sel;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic out_last;
    } sts_t;

endpackage

FILE: hw/rtl/cqwl_ctrl.sv
// Controller state machine of the circular queue with listing.
// Depends on cqwl_pkg; drives cqwl_dp through cmd_t and reads sts_t.
module cqwl_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cqwl_pkg::OP_W-1:0]    s_tuser,
    input  logic                         m_tready,
    input  cqwl_pkg::sts_t               sts,
    output cqwl_pkg::cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DEL_LOAD = 4'b0010,
        S_LST_LOAD = 4'b0100,
        S_SEND     = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new item only when nothing is in flight
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = cqwl_pkg::OUT_WORD;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        cqwl_pkg::OP_INSERT: begin
                            cmd.out_load = 1'b1;
                            if (sts.full) begin
                                cmd.out_sel = cqwl_pkg::OUT_FULL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.out_sel = cqwl_pkg::OUT_WORD;
                            end
                            state_next = S_SEND;
                        end
                        cqwl_pkg::OP_DELETE: begin
                            if (sts.empty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = cqwl_pkg::OUT_EMPTY;
                                state_next   = S_SEND;
                            end else begin
                                cmd.pop    = 1'b1;
                                state_next = S_DEL_LOAD;
                            end
                        end
                        cqwl_pkg::OP_LIST: begin
                            if (sts.empty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = cqwl_pkg::OUT_EMPTY;
                                state_next   = S_SEND;
                            end else begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LST_LOAD;
                            end
                        end
                        default: begin
                            // drop unused opcodes
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DEL_LOAD, S_LST_LOAD: begin
                // capture the word read last cycle
                cmd.out_load = 1'b1;
                cmd.out_sel  = cqwl_pkg::OUT_MEM;
                state_next   = S_SEND;
            end
            S_SEND: begin
                if (m_tready) begin
                    if (sts.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.list_next = 1'b1;
                        state_next    = S_LST_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/cqwl_dp.sv
// Datapath of the circular queue with listing: entry memory, pointers,
// count, listing walk and output register. Depends on cqwl_pkg.
module cqwl_dp #(
    parameter int DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cqwl_pkg::cmd_t                cmd,
    output cqwl_pkg::sts_t                sts,
    input  logic [cqwl_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [cqwl_pkg::DATA_W-1:0]   m_tdata,
    output logic [cqwl_pkg::ST_W-1:0]     m_tuser,
    output logic                          m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [cqwl_pkg::DATA_W-1:0] entry_mem [DEPTH];

    logic [IDX_W-1:0] head_reg,      head_next;
    logic [IDX_W-1:0] tail_reg,      tail_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [IDX_W-1:0] list_idx_reg,  list_idx_next;
    logic [CNT_W-1:0] list_left_reg, list_left_next;

    logic signed [cqwl_pkg::DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]                   rd_addr;
    logic                               rd_en;

    logic                               out_valid_reg, out_valid_next;
    logic signed [cqwl_pkg::DATA_W-1:0] out_data_reg,  out_data_next;
    logic [cqwl_pkg::ST_W-1:0]          out_status_reg, out_status_next;
    logic                               out_last_reg,  out_last_next;

    // Step an index with wrap at the last slot
    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    // Status toward the controller
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.out_last = out_last_reg;

    // Write port: store inserted words at the tail
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            entry_mem[tail_reg] <= s_tdata;
        end
    end

    // Read port: head for delete and walk start, walk index after that
    assign rd_en   = cmd.pop | cmd.list_start | cmd.list_next;
    assign rd_addr = cmd.list_next ? list_idx_reg : head_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Advance pointers, count and walk
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        list_idx_next  = list_idx_reg;
        list_left_next = list_left_reg;
        if (cmd.wr_en) begin
            tail_next  = adv(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop) begin
            head_next  = adv(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.list_start) begin
            list_idx_next  = adv(head_reg);
            list_left_next = count_reg - 1'b1;
        end
        if (cmd.list_next) begin
            list_idx_next  = adv(list_idx_reg);
            list_left_next = list_left_reg - 1'b1;
        end
    end

    // Output register: load a result, drop it once taken
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            case (cmd.out_sel)
                cqwl_pkg::OUT_WORD: begin
                    out_data_next   = s_tdata;
                    out_status_next = cqwl_pkg::ST_OK;
                    out_last_next   = 1'b1;
                end
                cqwl_pkg::OUT_FULL: begin
                    out_data_next   = '0;
                    out_status_next = cqwl_pkg::ST_OVERFLOW;
                    out_last_next   = 1'b1;
                end
                cqwl_pkg::OUT_EMPTY: begin
                    out_data_next   = '0;
                    out_status_next = cqwl_pkg::ST_EMPTY;
                    out_last_next   = 1'b1;
                end
                cqwl_pkg::OUT_MEM: begin
                    // the walk count is zero outside a listing
                    out_data_next   = rd_data_reg;
                    out_status_next = cqwl_pkg::ST_OK;
                    out_last_next   = (list_left_reg == '0);
                end
                default: begin
                    out_data_next   = '0;
                    out_status_next = cqwl_pkg::ST_OK;
                    out_last_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            list_left_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            list_idx_reg  <= list_idx_next;
            list_left_reg <= list_left_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/circular_queue_with_listing.sv
// Channel  Dir  Signals                      Contents
// s_       in   tvalid tready tdata tuser    data_in, opcode
// m_       out  tvalid tready tdata tuser    data_out, status, last (tlast)
//
// Insert loads its result as the item is taken; delete passes through S_DEL_LOAD
// and a listing of N entries through S_LST_LOAD for each entry, as reads are registered.
// An empty or full case gives a single result, shown in the cycle after the item is taken.
// Reset is synchronous on aresetn low and empties the queue; no clearing pass.
// A stall on m_tready holds the result and the block takes no new item.
//
// Top level of the circular queue with listing. Depends on cqwl_pkg,
// cqwl_ctrl, cqwl_dp and assert_macros.svh.
`include "assert_macros.svh"

module circular_queue_with_listing #(
    parameter int DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cqwl_pkg::DATA_W-1:0]   s_tdata,   // [31:0] data_in (signed)
    input  logic [cqwl_pkg::OP_W-1:0]     s_tuser,   // [1:0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cqwl_pkg::DATA_W-1:0]   m_tdata,   // [31:0] data_out (signed)
    output logic [cqwl_pkg::ST_W-1:0]     m_tuser,   // [1:0] status
    output logic                          m_tlast
);

    cqwl_pkg::cmd_t cmd;
    cqwl_pkg::sts_t sts;

    cqwl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cqwl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // No new item while a result is still pending
    `CQ_ASSERT(a_no_accept_pending, (s_tvalid && s_tready) |-> !m_tvalid, "accept while busy")
    // Never store into a full queue
    `CQ_ASSERT(a_no_write_full, cmd.wr_en |-> !sts.full, "write into full queue")
    // Never read from an empty queue
    `CQ_ASSERT(a_no_read_empty, (cmd.pop || cmd.list_start) |-> !sts.empty, "empty read")
    // Final result taken frees the input side
    `CQ_ASSERT(a_last_frees, (m_tvalid && m_tready && m_tlast) |=> s_tready, "stuck after last")

endmodule
